FILE: hdl/kpi_pkg.sv
package kpi_pkg;

  localparam int POINT_DEPTH = 256;
  localparam int PT_AW       = $clog2(POINT_DEPTH);
  localparam int PT_CW       = $clog2(POINT_DEPTH + 1);

  localparam int MODE_W   = 3;
  localparam int TIME_W   = 32;
  localparam int PTIME_W  = 24;
  localparam int LEVEL_W  = 8;
  localparam int STATUS_W = 2;
  localparam int POINT_W  = PTIME_W + LEVEL_W;

  localparam int DIFF_W  = TIME_W + 1;
  localparam int DL_W    = LEVEL_W + 1;
  localparam int NUM_W   = DIFF_W + DL_W;
  localparam int MAG_W   = NUM_W - 1;
  localparam int SPAN_W  = PTIME_W + 1;
  localparam int DVS_W   = PTIME_W;
  localparam int DIV_CW  = $clog2(MAG_W + 1);
  localparam int VAL_W   = MAG_W + 2;

  localparam logic [LEVEL_W-1:0] LEVEL_MAX = 8'd255;

  localparam logic [MODE_W-1:0] MODE_LOAD  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_ARM   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_START = 3'd2;
  localparam logic [MODE_W-1:0] MODE_TICK  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_STOP  = 3'd4;

  localparam logic [STATUS_W-1:0] ST_FREE = 2'd0;
  localparam logic [STATUS_W-1:0] ST_WAIT = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RUN  = 2'd2;

  localparam int RES_W = 3;
  localparam logic [RES_W-1:0] RES_NONE   = 3'd0;
  localparam logic [RES_W-1:0] RES_IDLE   = 3'd1;
  localparam logic [RES_W-1:0] RES_DRIVE0 = 3'd2;
  localparam logic [RES_W-1:0] RES_SPAN0  = 3'd3;
  localparam logic [RES_W-1:0] RES_INTERP = 3'd4;

  typedef struct packed {
    logic             cap;
    logic             load;
    logic             clear;
    logic             arm_read;
    logic             arm_set;
    logic             start;
    logic             adv;
    logic             fetch_read;
    logic             fetch_set;
    logic             mul;
    logic             div_start;
    logic [RES_W-1:0] res_sel;
    logic             out_load;
  } kpi_cmd_t;

  typedef struct packed {
    logic [MODE_W-1:0]   mode;
    logic                enable;
    logic [STATUS_W-1:0] chan_status;
    logic                few_points;
    logic                store_full;
    logic                next_valid;
    logic                cur_valid;
    logic                passed;
    logic                has_more;
    logic                span_zero;
    logic                div_busy;
    logic                out_free;
  } kpi_stat_t;

endpackage

FILE: hdl/kpi_div.sv
module kpi_div import kpi_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [MAG_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic [MAG_W-1:0] quotient,
  output logic [DVS_W-1:0] remainder,
  output logic             busy
);

  logic [DIV_CW-1:0] cnt;
  logic [DVS_W-1:0]  dvs;
  logic [DVS_W:0]    shifted;
  logic              ge;

  assign busy    = (cnt != '0);
  assign shifted = {remainder, quotient[MAG_W-1]};
  assign ge      = (shifted >= {1'b0, dvs});

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= DIV_CW'(MAG_W);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient  <= dividend;
      remainder <= '0;
      dvs       <= divisor;
    end else if (busy) begin
      quotient <= {quotient[MAG_W-2:0], ge};
      if (ge) begin
        remainder <= DVS_W'(shifted - {1'b0, dvs});
      end else begin
        remainder <= shifted[DVS_W-1:0];
      end
    end
  end

endmodule

FILE: hdl/kpi_ctrl.sv
module kpi_ctrl import kpi_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  kpi_stat_t stat,
  output kpi_cmd_t  cmd
);

  localparam int SW = 4;
  localparam logic [SW-1:0] S_IDLE  = 4'd0;
  localparam logic [SW-1:0] S_DEC   = 4'd1;
  localparam logic [SW-1:0] S_ARM   = 4'd2;
  localparam logic [SW-1:0] S_FETCH = 4'd3;
  localparam logic [SW-1:0] S_MUL   = 4'd4;
  localparam logic [SW-1:0] S_DIVI  = 4'd5;
  localparam logic [SW-1:0] S_DIV   = 4'd6;
  localparam logic [SW-1:0] S_FIN   = 4'd7;
  localparam logic [SW-1:0] S_OUT   = 4'd8;

  logic [SW-1:0] state;
  logic [SW-1:0] state_next;

  assign in_ready = (state == S_IDLE) && !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.cap    = 1'b1;
          state_next = S_DEC;
        end
      end
      S_DEC: begin
        cmd.res_sel = RES_IDLE;
        state_next  = S_OUT;
        if (stat.mode == MODE_STOP) begin
          cmd.clear   = 1'b1;
          cmd.res_sel = RES_DRIVE0;
        end else if (stat.enable) begin
          unique case (stat.mode)
            MODE_LOAD: begin
              cmd.load = (stat.chan_status == ST_FREE) && !stat.store_full;
            end
            MODE_ARM: begin
              if (stat.chan_status == ST_FREE) begin
                if (stat.few_points) begin
                  cmd.clear   = 1'b1;
                  cmd.res_sel = RES_DRIVE0;
                end else begin
                  cmd.arm_read = 1'b1;
                  state_next   = S_ARM;
                end
              end
            end
            MODE_START: begin
              if (stat.chan_status == ST_WAIT) begin
                cmd.start   = 1'b1;
                cmd.res_sel = RES_DRIVE0;
              end
            end
            MODE_TICK: begin
              if (stat.chan_status == ST_RUN && stat.next_valid) begin
                if (stat.passed) begin
                  cmd.adv = 1'b1;
                  if (stat.has_more) begin
                    cmd.fetch_read = 1'b1;
                    cmd.res_sel    = RES_NONE;
                    state_next     = S_FETCH;
                  end else begin
                    cmd.clear   = 1'b1;
                    cmd.res_sel = RES_DRIVE0;
                  end
                end else if (stat.cur_valid) begin
                  cmd.res_sel = RES_NONE;
                  state_next  = S_MUL;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_ARM: begin
        cmd.arm_set = 1'b1;
        state_next  = S_OUT;
      end
      S_FETCH: begin
        cmd.fetch_set = 1'b1;
        state_next    = S_MUL;
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_DIVI;
      end
      S_DIVI: begin
        if (stat.span_zero) begin
          cmd.res_sel = RES_SPAN0;
          state_next  = S_OUT;
        end else begin
          cmd.div_start = 1'b1;
          state_next    = S_DIV;
        end
      end
      S_DIV: begin
        if (!stat.div_busy) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        cmd.res_sel = RES_INTERP;
        state_next  = S_OUT;
      end
      S_OUT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

FILE: hdl/kpi_dpath.sv
module kpi_dpath import kpi_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  kpi_cmd_t            cmd,
  output kpi_stat_t           stat,
  input  logic                cfg_valid,
  input  logic                cfg_data,
  input  logic [MODE_W-1:0]   mode,
  input  logic [TIME_W-1:0]   time_ms,
  input  logic [PTIME_W-1:0]  point_time_ms,
  input  logic [LEVEL_W-1:0]  point_level,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [LEVEL_W-1:0]  pwm_level,
  output logic                pwm_write,
  output logic [STATUS_W-1:0] status
);

  logic                channel_enable;
  logic [STATUS_W-1:0] channel_status;
  logic [TIME_W-1:0]   start_time;
  logic [PT_CW-1:0]    points_loaded;
  logic [PT_CW-1:0]    read_index;
  logic [POINT_W-1:0]  current_point;
  logic                current_valid;
  logic [POINT_W-1:0]  next_point;
  logic                next_valid;

  logic [MODE_W-1:0]   mode_r;
  logic [TIME_W-1:0]   time_r;
  logic [PTIME_W-1:0]  ptime_r;
  logic [LEVEL_W-1:0]  plevel_r;
  logic [TIME_W-1:0]   elapsed;

  logic [POINT_W-1:0]  point_store [POINT_DEPTH];
  logic [POINT_W-1:0]  rdata;
  logic [PT_AW-1:0]    rd_addr;

  logic [LEVEL_W-1:0]  res_level;
  logic                res_wr;

  logic [PTIME_W-1:0]       ct;
  logic [PTIME_W-1:0]       nt;
  logic [LEVEL_W-1:0]       cl;
  logic [LEVEL_W-1:0]       nl;
  logic signed [DIFF_W-1:0] diff;
  logic signed [DL_W-1:0]   dl;
  logic signed [NUM_W-1:0]  prod;
  logic signed [NUM_W-1:0]  num_r;
  logic signed [SPAN_W-1:0] span_r;
  logic [NUM_W-1:0]         num_neg;
  logic [SPAN_W-1:0]        span_neg;
  logic [MAG_W-1:0]         dividend;
  logic [DVS_W-1:0]         divisor;
  logic [MAG_W-1:0]         quotient;
  logic [DVS_W-1:0]         remainder;
  logic                     div_busy;
  logic                     q_neg;
  logic signed [VAL_W-1:0]  q_ext;
  logic signed [VAL_W-1:0]  q_val;
  logic signed [VAL_W-1:0]  v_val;
  logic [LEVEL_W-1:0]       v_sat;

  assign ct = current_point[PTIME_W-1:0];
  assign cl = current_point[POINT_W-1:PTIME_W];
  assign nt = next_point[PTIME_W-1:0];
  assign nl = next_point[POINT_W-1:PTIME_W];

  assign stat.mode        = mode_r;
  assign stat.enable      = channel_enable;
  assign stat.chan_status = channel_status;
  assign stat.few_points  = (points_loaded < PT_CW'(2));
  assign stat.store_full  = (points_loaded == PT_CW'(POINT_DEPTH));
  assign stat.next_valid  = next_valid;
  assign stat.cur_valid   = current_valid;
  assign stat.passed      = ($signed({1'b0, nt}) < $signed(elapsed));
  assign stat.has_more    = (read_index < points_loaded);
  assign stat.span_zero   = (span_r == '0);
  assign stat.div_busy    = div_busy;
  assign stat.out_free    = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_enable <= 1'b0;
    end else if (cfg_valid) begin
      channel_enable <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      mode_r   <= mode;
      time_r   <= time_ms;
      ptime_r  <= point_time_ms;
      plevel_r <= point_level;
      elapsed  <= time_ms - start_time;
    end
  end

  assign rd_addr = cmd.arm_read ? '0 : read_index[PT_AW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      point_store[points_loaded[PT_AW-1:0]] <= {plevel_r, ptime_r};
    end
    if (cmd.arm_read || cmd.fetch_read) begin
      rdata <= point_store[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      channel_status <= ST_FREE;
      start_time     <= '0;
      points_loaded  <= '0;
      read_index     <= '0;
      current_point  <= '0;
      current_valid  <= 1'b0;
      next_point     <= '0;
      next_valid     <= 1'b0;
    end else begin
      if (cmd.load) begin
        points_loaded <= points_loaded + 1'b1;
      end
      if (cmd.arm_set) begin
        next_point     <= rdata;
        next_valid     <= 1'b1;
        current_point  <= '0;
        current_valid  <= 1'b0;
        read_index     <= PT_CW'(1);
        channel_status <= ST_WAIT;
      end
      if (cmd.start) begin
        start_time     <= time_r;
        channel_status <= ST_RUN;
      end
      if (cmd.adv) begin
        current_point <= next_point;
        current_valid <= 1'b1;
      end
      if (cmd.fetch_set) begin
        next_point <= rdata;
        read_index <= read_index + 1'b1;
      end
    end
  end

  assign diff = $signed({elapsed[TIME_W-1], elapsed}) - $signed({1'b0, 8'd0, ct});
  assign dl   = $signed({1'b0, nl}) - $signed({1'b0, cl});
  assign prod = NUM_W'(diff) * NUM_W'(dl);

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      num_r  <= prod;
      span_r <= $signed({1'b0, nt}) - $signed({1'b0, ct});
    end
  end

  assign num_neg  = -num_r;
  assign span_neg = -span_r;
  assign dividend = num_r[NUM_W-1] ? num_neg[MAG_W-1:0] : num_r[MAG_W-1:0];
  assign divisor  = span_r[SPAN_W-1] ? span_neg[DVS_W-1:0] : span_r[DVS_W-1:0];

  kpi_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.div_start),
    .dividend  (dividend),
    .divisor   (divisor),
    .quotient  (quotient),
    .remainder (remainder),
    .busy      (div_busy)
  );

  // A quotient of mixed signs is rounded toward minus infinity.
  assign q_neg = num_r[NUM_W-1] ^ span_r[SPAN_W-1];
  assign q_ext = $signed({2'b00, quotient});

  always_comb begin
    if (!q_neg) begin
      q_val = q_ext;
    end else if (remainder != '0) begin
      q_val = ~q_ext;
    end else begin
      q_val = -q_ext;
    end
    v_val = q_val + $signed({{(VAL_W-LEVEL_W){1'b0}}, cl});
    if (v_val < 0) begin
      v_sat = '0;
    end else if (v_val > $signed({{(VAL_W-LEVEL_W){1'b0}}, LEVEL_MAX})) begin
      v_sat = LEVEL_MAX;
    end else begin
      v_sat = v_val[LEVEL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.res_sel)
      RES_IDLE: begin
        res_level <= '0;
        res_wr    <= 1'b0;
      end
      RES_DRIVE0: begin
        res_level <= '0;
        res_wr    <= 1'b1;
      end
      RES_SPAN0: begin
        res_level <= nl;
        res_wr    <= 1'b1;
      end
      RES_INTERP: begin
        res_level <= v_sat;
        res_wr    <= 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      pwm_level <= res_level;
      pwm_write <= res_wr;
      status    <= channel_status;
    end
  end

endmodule

FILE: hdl/keyframe_pwm_interpolator_unit.sv
// Channel   Handshake              Word
// in        in_valid / in_ready    mode, time_ms, point_time_ms, point_level
// out       out_valid / out_ready  pwm_level, pwm_write, status
// cfg       cfg_valid / cfg_ready  cfg_data (channel enable)
//
// One item is in work at a time; the next is accepted no earlier than the cycle after its
// output word is loaded. Most items go from decode to the output load; an arm reads the
// point store first. An interpolating tick passes multiply, the 41-step restoring divider
// and a finish state, fetching a new point first if it advances; a zero span skips the divider.
// Reset is synchronous, holds both ready lines low and clears the channel to free; the point
// store is not cleared. A stalled output holds its word while the next item is worked on.
module keyframe_pwm_interpolator_unit import kpi_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [MODE_W-1:0]   mode,
  input  logic [TIME_W-1:0]   time_ms,
  input  logic [PTIME_W-1:0]  point_time_ms,
  input  logic [LEVEL_W-1:0]  point_level,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [LEVEL_W-1:0]  pwm_level,
  output logic                pwm_write,
  output logic [STATUS_W-1:0] status,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_data
);

  kpi_cmd_t  cmd;
  kpi_stat_t stat;

  assign cfg_ready = !rst;

  kpi_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  kpi_dpath u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .cfg_valid     (cfg_valid),
    .cfg_data      (cfg_data),
    .mode          (mode),
    .time_ms       (time_ms),
    .point_time_ms (point_time_ms),
    .point_level   (point_level),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .pwm_level     (pwm_level),
    .pwm_write     (pwm_write),
    .status        (status)
  );

endmodule

FILE: verif/keyframe_pwm_interpolator_unit_test.sv
`timescale 1ns / 100ps

module keyframe_pwm_interpolator_unit_test import kpi_pkg::*; ();

  localparam logic [MODE_W-1:0] MODE_UNUSED = 3'd5;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int ITEMS_PER_PHASE = 288;

  typedef struct packed {
    logic [LEVEL_W-1:0]  level;
    logic                written;
    logic [STATUS_W-1:0] status;
  } pwm_word_t;

  typedef struct {
    logic [MODE_W-1:0]  mode;
    logic [TIME_W-1:0]  now;
    logic [PTIME_W-1:0] ptime;
    logic [LEVEL_W-1:0] plevel;
    logic               fixed;
    pwm_word_t          word;
  } step_row_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [MODE_W-1:0]   mode = '0;
  logic [TIME_W-1:0]   time_ms = '0;
  logic [PTIME_W-1:0]  point_time_ms = '0;
  logic [LEVEL_W-1:0]  point_level = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [LEVEL_W-1:0]  pwm_level;
  logic                pwm_write;
  logic [STATUS_W-1:0] status;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic                cfg_data = 1'b0;

  keyframe_pwm_interpolator_unit dut (.*);

  always #5 clk = ~clk;

  // Channel state as the block should hold it.
  logic                model_enable = 1'b0;
  logic [STATUS_W-1:0] ch_status = ST_FREE;
  logic [TIME_W-1:0]   run_start = '0;
  logic [POINT_W-1:0]  points [POINT_DEPTH];
  int                  n_loaded = 0;
  int                  rd_idx = 0;
  logic [POINT_W-1:0]  cur_pt = '0;
  logic                cur_ok = 1'b0;
  logic [POINT_W-1:0]  nxt_pt = '0;
  logic                nxt_ok = 1'b0;

  pwm_word_t pwm_words_due [$];
  int        words_taken = 0;
  int        cfg_taken = 0;
  int        live_items = 0;
  int        fails = 0;
  int        idle_cycles = 0;
  int        gap_pct = 0;
  int        stall_pct = 0;
  logic      fixed_row = 1'b0;
  pwm_word_t fixed_word = '0;
  bit        full_store_done = 1'b0;

  step_row_t directed_rows [0:23] = '{
    '{MODE_TICK,   32'h0000_0000, 24'h000000, 8'h00, 1'b1, '{8'd0, 1'b0, ST_FREE}},
    '{MODE_START,  32'h0000_0005, 24'h000000, 8'h00, 1'b1, '{8'd0, 1'b0, ST_FREE}},
    '{MODE_ARM,    32'h0000_0000, 24'h000000, 8'h00, 1'b1, '{8'd0, 1'b1, ST_FREE}},
    '{MODE_LOAD,   32'h0000_0000, 24'h000000, 8'h00, 1'b1, '{8'd0, 1'b0, ST_FREE}},
    '{MODE_ARM,    32'h0000_0000, 24'h000000, 8'h00, 1'b1, '{8'd0, 1'b1, ST_FREE}},
    '{MODE_LOAD,   32'h0000_0000, 24'h000000, 8'h00, 1'b1, '{8'd0, 1'b0, ST_FREE}},
    '{MODE_LOAD,   32'h0000_0000, 24'h00000A, 8'hFF, 1'b1, '{8'd0, 1'b0, ST_FREE}},
    '{MODE_LOAD,   32'h0000_0000, 24'h00000A, 8'h64, 1'b1, '{8'd0, 1'b0, ST_FREE}},
    '{MODE_LOAD,   32'h0000_0000, 24'hFFFFFF, 8'h00, 1'b1, '{8'd0, 1'b0, ST_FREE}},
    '{MODE_LOAD,   32'h0000_0000, 24'h000005, 8'hC8, 1'b1, '{8'd0, 1'b0, ST_FREE}},
    '{MODE_UNUSED, 32'hFFFF_FFFF, 24'hFFFFFF, 8'hFF, 1'b1, '{8'd0, 1'b0, ST_FREE}},
    '{MODE_ARM,    32'h0000_0000, 24'h000000, 8'h00, 1'b1, '{8'd0, 1'b0, ST_WAIT}},
    '{MODE_LOAD,   32'h0000_0000, 24'h123456, 8'hAA, 1'b1, '{8'd0, 1'b0, ST_WAIT}},
    '{MODE_ARM,    32'h0000_0000, 24'h000000, 8'h00, 1'b1, '{8'd0, 1'b0, ST_WAIT}},
    '{MODE_TICK,   32'h0000_0000, 24'h000000, 8'h00, 1'b1, '{8'd0, 1'b0, ST_WAIT}},
    '{MODE_START,  32'h8000_0000, 24'h000000, 8'h00, 1'b1, '{8'd0, 1'b1, ST_RUN}},
    '{MODE_START,  32'h0000_0007, 24'h000000, 8'h00, 1'b1, '{8'd0, 1'b0, ST_RUN}},
    '{MODE_TICK,   32'h8000_0000, 24'h000000, 8'h00, 1'b1, '{8'd0, 1'b0, ST_RUN}},
    '{MODE_TICK,   32'h8000_0005, 24'h000000, 8'h00, 1'b0, '{8'd0, 1'b0, ST_FREE}},
    '{MODE_TICK,   32'h8000_000B, 24'h000000, 8'h00, 1'b0, '{8'd0, 1'b0, ST_FREE}},
    '{MODE_TICK,   32'h8000_000C, 24'h000000, 8'h00, 1'b0, '{8'd0, 1'b0, ST_FREE}},
    '{MODE_TICK,   32'hFFFF_FFFF, 24'h000000, 8'h00, 1'b0, '{8'd0, 1'b0, ST_FREE}},
    '{MODE_TICK,   32'hFFFF_FFFF, 24'h000000, 8'h00, 1'b1, '{8'd0, 1'b1, ST_FREE}},
    '{MODE_STOP,   32'hFFFF_FFFF, 24'h000000, 8'h00, 1'b1, '{8'd0, 1'b1, ST_FREE}}
  };

  function automatic void clear_channel();
    ch_status = ST_FREE;
    run_start = '0;
    n_loaded = 0;
    rd_idx = 0;
    cur_pt = '0;
    cur_ok = 1'b0;
    nxt_pt = '0;
    nxt_ok = 1'b0;
  endfunction

  // Linear interpolation between the current and next points, floored and
  // clamped to the level range.
  function automatic logic [LEVEL_W-1:0] blend_level(longint elapsed);
    longint ct, nt, cl, nl, span, num, q, v;
    ct = cur_pt[PTIME_W-1:0];
    nt = nxt_pt[PTIME_W-1:0];
    cl = cur_pt[POINT_W-1:PTIME_W];
    nl = nxt_pt[POINT_W-1:PTIME_W];
    span = nt - ct;
    if (span == 0) begin
      v = nl;
    end else begin
      num = (elapsed - ct) * (nl - cl);
      q = num / span;
      if ((num % span) != 0 && ((num < 0) != (span < 0))) begin
        q = q - 1;
      end
      v = cl + q;
    end
    if (v < 0) begin
      v = 0;
    end
    if (v > 255) begin
      v = 255;
    end
    return v[LEVEL_W-1:0];
  endfunction

  function automatic pwm_word_t envelope_step(logic [MODE_W-1:0] m, logic [TIME_W-1:0] now,
                                              logic [PTIME_W-1:0] pt, logic [LEVEL_W-1:0] pl);
    pwm_word_t w;
    logic signed [TIME_W-1:0] diff;
    longint elapsed;
    bit ended;
    w = '0;
    ended = 1'b0;
    if (m == MODE_STOP) begin
      clear_channel();
      w.written = 1'b1;
    end else if (model_enable) begin
      case (m)
        MODE_LOAD: begin
          if (ch_status == ST_FREE && n_loaded < POINT_DEPTH) begin
            points[n_loaded] = {pl, pt};
            n_loaded++;
          end
        end
        MODE_ARM: begin
          if (ch_status == ST_FREE) begin
            if (n_loaded < 2) begin
              clear_channel();
              w.written = 1'b1;
            end else begin
              nxt_pt = points[0];
              nxt_ok = 1'b1;
              cur_ok = 1'b0;
              cur_pt = '0;
              rd_idx = 1;
              ch_status = ST_WAIT;
            end
          end
        end
        MODE_START: begin
          if (ch_status == ST_WAIT) begin
            run_start = now;
            ch_status = ST_RUN;
            w.written = 1'b1;
          end
        end
        MODE_TICK: begin
          if (ch_status == ST_RUN && nxt_ok) begin
            diff = now - run_start;
            elapsed = diff;
            if (longint'(nxt_pt[PTIME_W-1:0]) < elapsed) begin
              cur_pt = nxt_pt;
              cur_ok = 1'b1;
              if (rd_idx < n_loaded) begin
                nxt_pt = points[rd_idx];
                rd_idx++;
              end else begin
                clear_channel();
                w.written = 1'b1;
                ended = 1'b1;
              end
            end
            if (!ended && cur_ok) begin
              w.level = blend_level(elapsed);
              w.written = 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end
    w.status = ch_status;
    return w;
  endfunction

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    pwm_word_t got, want;
    bit busy;
    busy = 1'b0;
    if (!rst) begin
      if (in_valid && in_ready) begin
        want = envelope_step(mode, time_ms, point_time_ms, point_level);
        if (fixed_row) begin
          want = fixed_word;
        end
        pwm_words_due.push_back(want);
        words_taken++;
        busy = 1'b1;
      end
      if (out_valid && out_ready) begin
        got = '{pwm_level, pwm_write, status};
        busy = 1'b1;
        if (pwm_words_due.size() == 0) begin
          $error("unexpected word: pwm_level %0d pwm_write %0d status %0d",
                 got.level, got.written, got.status);
          fails++;
        end else begin
          want = pwm_words_due.pop_front();
          if (got.level !== want.level) begin
            $error("pwm_level: expected %0d, got %0d", want.level, got.level);
            fails++;
          end
          if (got.written !== want.written) begin
            $error("pwm_write: expected %0d, got %0d", want.written, got.written);
            fails++;
          end
          if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            fails++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        model_enable = cfg_data;
        cfg_taken++;
        busy = 1'b1;
      end
    end
    if (busy) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("keyframe_pwm_interpolator_unit_test: done, errors");
      $finish;
    end
  end

  task automatic send_word(input logic [MODE_W-1:0] m, input logic [TIME_W-1:0] now,
                           input logic [PTIME_W-1:0] pt, input logic [LEVEL_W-1:0] pl,
                           input logic fixed, input pwm_word_t w);
    int target;
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    mode <= m;
    time_ms <= now;
    point_time_ms <= pt;
    point_level <= pl;
    fixed_row = fixed;
    fixed_word = w;
    if (model_enable || m == MODE_STOP) begin
      live_items++;
    end
    target = words_taken + 1;
    do @(negedge clk); while (words_taken < target);
  endtask

  task automatic send_noise();
    send_word(MODE_W'($urandom_range(0, 7)), $urandom, PTIME_W'($urandom),
              LEVEL_W'($urandom), 1'b0, '0);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pwm_words_due.size() != 0) begin
      @(negedge clk);
    end
  endtask

  task automatic set_enable(input logic v);
    int target;
    drain_results();
    repeat (4) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    target = cfg_taken + 1;
    do @(negedge clk); while (cfg_taken < target);
    cfg_valid <= 1'b0;
  endtask

  // One load, arm, start and tick sequence with random content and some noise.
  task automatic play_envelope();
    int n_pts, t, r;
    logic [TIME_W-1:0] now;
    if (ch_status != ST_FREE) begin
      send_word(MODE_STOP, $urandom, '0, '0, 1'b0, '0);
    end
    r = $urandom_range(99);
    if (r < 6) begin
      n_pts = $urandom_range(0, 1);
    end else if (r < 8 && !full_store_done && model_enable) begin
      n_pts = POINT_DEPTH + 2;
      full_store_done = 1'b1;
    end else begin
      n_pts = $urandom_range(2, 8);
    end
    t = $urandom_range(0, 30);
    for (int i = 0; i < n_pts; i++) begin
      if ($urandom_range(99) < 4) begin
        send_noise();
      end
      if ($urandom_range(9) == 0) begin
        t = $urandom_range(0, 24'hFFFFFF);
      end else begin
        t = t + $urandom_range(0, 40);
        if (t > 24'hFFFFFF) begin
          t = 24'hFFFFFF;
        end
      end
      send_word(MODE_LOAD, $urandom, PTIME_W'(t), LEVEL_W'($urandom), 1'b0, '0);
    end
    send_word(MODE_ARM, $urandom, PTIME_W'($urandom), LEVEL_W'($urandom), 1'b0, '0);
    if ($urandom_range(99) < 5) begin
      send_noise();
    end
    now = $urandom;
    send_word(MODE_START, now, PTIME_W'($urandom), LEVEL_W'($urandom), 1'b0, '0);
    for (int k = 0; k < 80 && ch_status == ST_RUN; k++) begin
      r = $urandom_range(99);
      if (r < 2) begin
        send_word(MODE_STOP, $urandom, '0, '0, 1'b0, '0);
      end else if (r < 5) begin
        send_noise();
      end else begin
        if (r < 9) begin
          now = $urandom;
        end else begin
          now = now + $urandom_range(0, 25);
        end
        send_word(MODE_TICK, now, PTIME_W'($urandom), LEVEL_W'($urandom), 1'b0, '0);
      end
    end
  endtask

  initial begin
    int gaps [4];
    int stalls [4];
    gaps = '{0, 45, 0, 30};
    stalls = '{0, 0, 45, 30};
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    set_enable(1'b1);
    foreach (directed_rows[i]) begin
      send_word(directed_rows[i].mode, directed_rows[i].now, directed_rows[i].ptime,
                directed_rows[i].plevel, directed_rows[i].fixed, directed_rows[i].word);
    end

    live_items = 0;
    for (int p = 0; p < 4; p++) begin
      gap_pct = gaps[p];
      stall_pct = stalls[p];
      while (live_items < p * ITEMS_PER_PHASE + ITEMS_PER_PHASE / 2) begin
        play_envelope();
      end
      // A short stretch with the channel disabled; only stop may act.
      set_enable(1'b0);
      repeat (2) play_envelope();
      set_enable(1'b1);
      while (live_items < (p + 1) * ITEMS_PER_PHASE) begin
        play_envelope();
      end
    end

    drain_results();
    repeat (60) @(negedge clk);
    if (fails == 0) begin
      $display("keyframe_pwm_interpolator_unit_test: done, clean");
    end else begin
      $display("keyframe_pwm_interpolator_unit_test: done, errors");
    end
    $finish;
  end

endmodule

FILE: sim.f
hdl/kpi_pkg.sv
hdl/kpi_div.sv
hdl/kpi_ctrl.sv
hdl/kpi_dpath.sv
hdl/keyframe_pwm_interpolator_unit.sv
verif/keyframe_pwm_interpolator_unit_test.sv
